// ----- hdl/asl_pkg.sv -----
// Shared types and constants for the Annex-B SPS/PPS locator.
package asl_pkg;

  localparam int unsigned MaxStreamBytesDef = 65536;
  localparam int unsigned PosCap            = 65536;
  localparam int unsigned PosW              = 17;
  localparam int unsigned OffW              = 16;
  localparam int unsigned LenW              = 17;
  localparam int unsigned TypeW             = 5;
  localparam int unsigned OutTdataW         = 72;

  localparam logic [7:0] StartByte = 8'h01;
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] TypeMask  = 8'h1F;

  localparam logic [TypeW-1:0] NalSps = 5'd7;
  localparam logic [TypeW-1:0] NalPps = 5'd8;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusMissing  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic            seen;
    logic [OffW-1:0] start;
    logic [LenW-1:0] size;
  } unit_rec_t;

  typedef struct packed {
    unit_rec_t sps;
    unit_rec_t pps;
  } rec_pair_t;

  typedef struct packed {
    logic [LenW-1:0] pps_length;
    logic [OffW-1:0] pps_offset;
    logic            pps_found;
    logic [LenW-1:0] sps_length;
    logic [OffW-1:0] sps_offset;
    logic            sps_found;
    logic [1:0]      status;
  } result_t;

endpackage

// ----- hdl/asl_core.sv -----
// Scanner state, per-byte update and registered result for the locator.
module asl_core import asl_pkg::*; #(
  parameter int unsigned MAX_STREAM_BYTES = MaxStreamBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  output logic     item_ready_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output result_t  res_o
);

  localparam int unsigned Lim = (MAX_STREAM_BYTES > PosCap) ? PosCap : MAX_STREAM_BYTES;
  localparam logic [PosW-1:0] LimPos   = PosW'(Lim);
  localparam logic [PosW-1:0] LimPosM1 = PosW'(Lim - 1);

  function automatic rec_pair_t close_unit(
    input rec_pair_t       recs,
    input logic            open,
    input logic            captured,
    input logic [TypeW-1:0] utype,
    input logic [OffW-1:0] ustart,
    input logic [PosW-1:0] end_pos
  );
    rec_pair_t       r;
    logic [LenW-1:0] len;
    r   = recs;
    len = LenW'(end_pos - {1'b0, ustart});
    if (open && captured && (end_pos > {1'b0, ustart})) begin
      if (utype == NalSps && !recs.sps.seen) begin
        r.sps.seen  = 1'b1;
        r.sps.start = ustart;
        r.sps.size  = len;
      end else if (utype == NalPps && !recs.pps.seen) begin
        r.pps.seen  = 1'b1;
        r.pps.start = ustart;
        r.pps.size  = len;
      end
    end
    return r;
  endfunction

  logic [1:0]       zero_run_q, zero_run_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             in_unit_q, in_unit_d;
  logic [OffW-1:0]  unit_start_q, unit_start_d;
  logic [TypeW-1:0] unit_type_q, unit_type_d;
  logic             captured_q, captured_d;
  rec_pair_t        recs_q, recs_d, recs_fin;
  logic             overflow_q, overflow_d;
  logic             res_valid_q;
  result_t          res_q, res_d;
  logic             fire;
  logic             start_code;

  assign item_ready_o = !item_i.last_byte || !res_valid_q || res_ready_i;
  assign fire         = item_valid_i && item_ready_o;
  assign start_code   = (item_i.data_byte == StartByte) && (zero_run_q >= 2'd2);

  always_comb begin
    zero_run_d   = zero_run_q;
    pos_d        = pos_q;
    in_unit_d    = in_unit_q;
    unit_start_d = unit_start_q;
    unit_type_d  = unit_type_q;
    captured_d   = captured_q;
    recs_d       = recs_q;
    overflow_d   = overflow_q;
    if (pos_q >= LimPos) begin
      overflow_d = 1'b1;
      in_unit_d  = 1'b0;
    end else begin
      if (start_code) begin
        recs_d       = close_unit(recs_q, in_unit_q, captured_q, unit_type_q, unit_start_q,
                                  pos_q - {{(PosW-2){1'b0}}, zero_run_q});
        in_unit_d    = (pos_q < LimPosM1);
        unit_start_d = OffW'(pos_q + PosW'(1));
        captured_d   = 1'b0;
        unit_type_d  = '0;
      end else if (in_unit_q && !captured_q) begin
        unit_type_d = TypeW'(item_i.data_byte & TypeMask);
        captured_d  = 1'b1;
      end
      if (item_i.data_byte == ZeroByte) begin
        zero_run_d = (zero_run_q == 2'd3) ? 2'd3 : zero_run_q + 2'd1;
      end else begin
        zero_run_d = 2'd0;
      end
      pos_d = pos_q + PosW'(1);
    end

    recs_fin = recs_d;
    if (!overflow_d) begin
      recs_fin = close_unit(recs_d, in_unit_d, captured_d, unit_type_d, unit_start_d, pos_d);
    end

    if (overflow_d) begin
      res_d.status = StatusOverflow;
    end else if (recs_fin.sps.seen && recs_fin.pps.seen) begin
      res_d.status = StatusOk;
    end else begin
      res_d.status = StatusMissing;
    end
    res_d.sps_found  = recs_fin.sps.seen;
    res_d.sps_offset = recs_fin.sps.seen ? recs_fin.sps.start : '0;
    res_d.sps_length = recs_fin.sps.seen ? recs_fin.sps.size  : '0;
    res_d.pps_found  = recs_fin.pps.seen;
    res_d.pps_offset = recs_fin.pps.seen ? recs_fin.pps.start : '0;
    res_d.pps_length = recs_fin.pps.seen ? recs_fin.pps.size  : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q   <= '0;
      pos_q        <= '0;
      in_unit_q    <= 1'b0;
      unit_start_q <= '0;
      unit_type_q  <= '0;
      captured_q   <= 1'b0;
      recs_q       <= '0;
      overflow_q   <= 1'b0;
    end else if (fire) begin
      if (item_i.last_byte) begin
        zero_run_q   <= '0;
        pos_q        <= '0;
        in_unit_q    <= 1'b0;
        unit_start_q <= '0;
        unit_type_q  <= '0;
        captured_q   <= 1'b0;
        recs_q       <= '0;
        overflow_q   <= 1'b0;
      end else begin
        zero_run_q   <= zero_run_d;
        pos_q        <= pos_d;
        in_unit_q    <= in_unit_d;
        unit_start_q <= unit_start_d;
        unit_type_q  <= unit_type_d;
        captured_q   <= captured_d;
        recs_q       <= recs_d;
        overflow_q   <= overflow_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire && item_i.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && item_i.last_byte) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/annexb_sps_pps_locator.sv -----
// Top level: Annex-B byte stream scanner reporting first SPS and PPS location.
// The last byte is held in the input register and then loads the result register.
// Throughput: one byte per cycle unless stalled; the result register frees the input side.
// A result waiting downstream stalls only the next last byte.
// Reset (rst_ni low, asynchronous) clears all scan state; the scan state also
// returns to reset after each last byte.
module annexb_sps_pps_locator import asl_pkg::*; #(
  parameter int unsigned MAX_STREAM_BYTES = MaxStreamBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  input  logic                 s_axis_tlast,  // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] status, [2] sps_found, [18:3] sps_offset, [35:19] sps_length,
  // [36] pps_found, [52:37] pps_offset, [69:53] pps_length, [71:70] zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     core_ready;
  logic     advance;
  result_t  res;

  assign advance       = in_valid_q && core_ready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.data_byte <= s_axis_tdata;
      in_item_q.last_byte <= s_axis_tlast;
    end
  end

  asl_core #(
    .MAX_STREAM_BYTES(MAX_STREAM_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(in_valid_q),
    .item_i      (in_item_q),
    .item_ready_o(core_ready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

// ----- tb/annexb_sps_pps_locator_tb.sv -----
// Testbench for annexb_sps_pps_locator: directed and random Annex-B streams against a predictor.
`timescale 1ns / 100ps

module annexb_sps_pps_locator_tb import asl_pkg::*; ();

  localparam int unsigned StreamLimit =
    (MaxStreamBytesDef > PosCap) ? PosCap : MaxStreamBytesDef;
  localparam int unsigned RandItems = 1100;
  localparam int unsigned LongHold  = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  result_t              seen_report;

  // scan state of the predictor
  logic [1:0]       run_zeros;
  logic [PosW-1:0]  scan_pos;
  logic             unit_open;
  logic [OffW-1:0]  unit_first;
  logic [TypeW-1:0] unit_kind;
  logic             kind_known;
  unit_rec_t        sps_rec;
  unit_rec_t        pps_rec;
  logic             past_limit;

  result_t    pending_reports[$];
  logic [7:0] stream_bytes[$];
  int         mismatch_cnt = 0;
  int         gap_pct = 20;
  bit         calm_tail = 1'b0;
  int         hold_reqs = 0;
  int         hold_taken = 0;
  int         hold_left = 0;
  int         stall_left = 0;

  assign seen_report = m_axis_tdata[$bits(result_t)-1:0];

  annexb_sps_pps_locator #(
    .MAX_STREAM_BYTES(MaxStreamBytesDef)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(200_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_scan();
    run_zeros  = '0;
    scan_pos   = '0;
    unit_open  = 1'b0;
    unit_first = '0;
    unit_kind  = '0;
    kind_known = 1'b0;
    sps_rec    = '0;
    pps_rec    = '0;
    past_limit = 1'b0;
  endfunction

  function automatic void finish_unit(input int unsigned stop);
    int unsigned len;
    if (!unit_open || !kind_known || stop <= unit_first) return;
    len = stop - unit_first;
    if (unit_kind == NalSps && !sps_rec.seen) begin
      sps_rec.seen  = 1'b1;
      sps_rec.start = unit_first;
      sps_rec.size  = len[LenW-1:0];
    end else if (unit_kind == NalPps && !pps_rec.seen) begin
      pps_rec.seen  = 1'b1;
      pps_rec.start = unit_first;
      pps_rec.size  = len[LenW-1:0];
    end
  endfunction

  // Advances the scan by one byte; returns 1 with the report on the last byte.
  function automatic bit locate_byte(input logic [7:0] b, input logic l,
                                     output result_t rep);
    int unsigned p;
    int unsigned nxt;
    rep = '0;
    if (scan_pos >= StreamLimit) begin
      past_limit = 1'b1;
      unit_open  = 1'b0;
    end else begin
      p   = scan_pos;
      nxt = p + 1;
      if (b == StartByte && run_zeros >= 2) begin
        finish_unit(p - run_zeros);
        unit_open  = (nxt < StreamLimit);
        unit_first = nxt[OffW-1:0];
        kind_known = 1'b0;
        unit_kind  = '0;
      end else if (unit_open && !kind_known) begin
        unit_kind  = b[TypeW-1:0] & TypeMask[TypeW-1:0];
        kind_known = 1'b1;
      end
      if (b == ZeroByte) run_zeros = (run_zeros < 3) ? run_zeros + 2'd1 : 2'd3;
      else run_zeros = '0;
      scan_pos = nxt[PosW-1:0];
    end
    if (!l) return 1'b0;
    if (!past_limit) finish_unit(scan_pos);
    if (past_limit) rep.status = StatusOverflow;
    else if (sps_rec.seen && pps_rec.seen) rep.status = StatusOk;
    else rep.status = StatusMissing;
    if (sps_rec.seen) begin
      rep.sps_found  = 1'b1;
      rep.sps_offset = sps_rec.start;
      rep.sps_length = sps_rec.size;
    end
    if (pps_rec.seen) begin
      rep.pps_found  = 1'b1;
      rep.pps_offset = pps_rec.start;
      rep.pps_length = pps_rec.size;
    end
    clear_scan();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [LenW-1:0] want,
                                      input logic [LenW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic check_report(input result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      $error("result transaction with no expected report");
      mismatch_cnt++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("status",     want.status,     got.status);
    check_field("sps_found",  want.sps_found,  got.sps_found);
    check_field("sps_offset", want.sps_offset, got.sps_offset);
    check_field("sps_length", want.sps_length, got.sps_length);
    check_field("pps_found",  want.pps_found,  got.pps_found);
    check_field("pps_offset", want.pps_offset, got.pps_offset);
    check_field("pps_length", want.pps_length, got.pps_length);
  endtask

  // result side: checks accepted reports, random stalls and the long hold
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_report(seen_report);
    if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 99) < 12) begin
      stall_left = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    result_t rep;
    if (!calm_tail && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (locate_byte(b, l, rep)) pending_reports.push_back(rep);
  endtask

  task automatic send_stream();
    int n;
    n = stream_bytes.size();
    for (int i = 0; i < n; i++) send_byte(stream_bytes[i], i == n - 1);
    stream_bytes.delete();
  endtask

  function automatic logic [7:0] noise_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return ZeroByte;
    if (sel == 3) return StartByte;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed unit sequences; some noise and cut-off streams.
  task automatic build_random_stream();
    int units;
    int plen;
    int hi;
    logic [TypeW-1:0] kind;
    stream_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) stream_bytes.push_back(noise_byte());
      return;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) stream_bytes.push_back(noise_byte());
    units = $urandom_range(1, 5);
    repeat (units) begin
      if ($urandom_range(0, 1)) stream_bytes.push_back(ZeroByte);
      stream_bytes.push_back(ZeroByte);
      stream_bytes.push_back(ZeroByte);
      stream_bytes.push_back(StartByte);
      case ($urandom_range(0, 5))
        0, 1:    kind = NalSps;
        2, 3:    kind = NalPps;
        4:       kind = TypeW'($urandom_range(0, 31));
        default: kind = '0;
      endcase
      hi = $urandom_range(0, 7);
      if (kind != '0) stream_bytes.push_back({hi[2:0], kind});
      plen = $urandom_range(0, 10);
      repeat (plen) stream_bytes.push_back(noise_byte());
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) stream_bytes.push_back(ZeroByte);
    end
    if ($urandom_range(0, 7) == 0 && stream_bytes.size() > 1)
      repeat ($urandom_range(1, stream_bytes.size() - 1)) void'(stream_bytes.pop_back());
  endtask

  task automatic test_nal_basics();
    gap_pct = 20;
    stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'hBB, 8'h00, 8'h00, 8'h01,
                     8'h68, 8'hCC, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h11, 8'h22};
    send_stream();
  endtask

  task automatic test_corner_streams();
    gap_pct = 20;
    stream_bytes = '{8'hFF};
    send_stream();
    // empty unit, long zero run before a start code, trailing zeros at the end
    stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hE7, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h28, 8'h00, 8'h00};
    send_stream();
    stream_bytes = '{8'h00, 8'h00, 8'h01};
    send_stream();
  endtask

  task automatic test_output_stall();
    gap_pct = 0;
    hold_reqs <= hold_reqs + 1;
    repeat (8) begin
      build_random_stream();
      send_stream();
    end
  endtask

  task automatic test_random_streams();
    int sent;
    sent = 0;
    while (sent < RandItems) begin
      if (sent > RandItems * 85 / 100) calm_tail = 1'b1;
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      build_random_stream();
      sent += stream_bytes.size();
      send_stream();
    end
  endtask

  initial begin
    clear_scan();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_nal_basics();
    test_corner_streams();
    test_output_stall();
    test_random_streams();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
